@@ hdl/range_min_point_update_macros.svh @@
// Assertion macros shared by the range minimum block.
// Define ASSERT_OFF to compile every check away.
`ifndef RANGE_MIN_POINT_UPDATE_MACROS_SVH
`define RANGE_MIN_POINT_UPDATE_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define RMPU_ASSERT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
		else $error("range_min_point_update: check failed");

// Condition must never be true at a clock edge outside reset.
`define RMPU_NEVER(lbl, ck, rn, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
		else $error("range_min_point_update: forbidden condition seen");

`else

`define RMPU_ASSERT(lbl, ck, rn, prop)
`define RMPU_NEVER(lbl, ck, rn, cond)

`endif

`endif

@@ hdl/rmpu_pkg.sv @@
package rmpu_pkg;

	localparam int IDX_W = 10;
	localparam int LEN_W = 11;
	localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;
	localparam int QUEUE_DEPTH = 2;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	// What the back end has to do with a queued item.
	typedef enum logic [1:0] {
		CMD_UPDATE,
		CMD_QUERY,
		CMD_EMPTY,
		CMD_ERROR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [IDX_W-1:0] first;
		logic [IDX_W-1:0] last;
	} cmd_ctrl_t;

endpackage

@@ hdl/rmpu_front.sv @@
module rmpu_front #(
	parameter int MAX_LENGTH  = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rmpu_pkg::LEN_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          opcode,
	input  logic [rmpu_pkg::IDX_W-1:0]    first_index,
	input  logic [rmpu_pkg::IDX_W-1:0]    last_index,
	input  logic [VALUE_WIDTH-1:0]        new_value,
	input  logic                          init_done,
	input  logic                          q_full,
	output logic                          q_push,
	output rmpu_pkg::cmd_ctrl_t           q_ctrl,
	output logic [VALUE_WIDTH-1:0]        q_value
);

	logic [rmpu_pkg::LEN_W-1:0] len_q;
	logic                       first_ok;
	logic                       last_ok;
	logic                       drop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= rmpu_pkg::LEN_RESET;
		end else if (cfg_valid) begin
			len_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;

	// A position is live when below both the programmed length and the tree size.
	assign first_ok = ({1'b0, first_index} < len_q) &&
		(32'(first_index) < 32'(MAX_LENGTH));
	assign last_ok  = ({1'b0, last_index} < len_q) &&
		(32'(last_index) < 32'(MAX_LENGTH));

	always_comb begin
		q_ctrl.first = first_index;
		q_ctrl.last  = last_index;
		drop         = 1'b0;
		if (opcode == rmpu_pkg::OP_UPDATE) begin
			q_ctrl.kind = rmpu_pkg::CMD_UPDATE;
			drop        = !first_ok;
		end else if (!(first_ok && last_ok)) begin
			q_ctrl.kind = rmpu_pkg::CMD_ERROR;
		end else if (first_index > last_index) begin
			q_ctrl.kind = rmpu_pkg::CMD_EMPTY;
		end else begin
			q_ctrl.kind = rmpu_pkg::CMD_QUERY;
		end
	end

	assign in_ready = init_done && !q_full;
	assign q_push   = in_valid && in_ready && !drop;
	assign q_value  = new_value;

endmodule

@@ hdl/rmpu_queue.sv @@
`include "range_min_point_update_macros.svh"

module rmpu_queue #(
	parameter int WIDTH = 56
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int DEPTH = rmpu_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_FULL);
	assign empty    = (count_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`RMPU_NEVER(a_no_overflow, clk, arst_n, push && full && !pop)
	`RMPU_NEVER(a_no_underflow, clk, arst_n, pop && empty)

endmodule

@@ hdl/rmpu_back.sv @@
`include "range_min_point_update_macros.svh"

module rmpu_back #(
	parameter int MAX_LENGTH  = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_empty,
	output logic                   q_pop,
	input  rmpu_pkg::cmd_ctrl_t    q_ctrl,
	input  logic [VALUE_WIDTH-1:0] q_value,
	output logic                   init_done,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [VALUE_WIDTH-1:0] out_minimum,
	output logic                   out_error
);

	localparam int AW = $clog2(2 * MAX_LENGTH);
	localparam int PW = AW + 1;
	localparam int TREE_SIZE = 2 * MAX_LENGTH;
	localparam logic [PW-1:0] LEAF_BASE = PW'(MAX_LENGTH);
	localparam logic [AW-1:0] CLR_LAST  = AW'(TREE_SIZE - 1);
	localparam logic [PW-1:0] ROOT      = PW'(1);
	localparam logic [VALUE_WIDTH-1:0] SIGN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ULEAF,
		ST_ULEVEL,
		ST_QTEST,
		ST_QLO,
		ST_QHI
	} state_t;

	// Values are stored with the sign bit flipped so unsigned compare orders them.
	logic [VALUE_WIDTH-1:0] tree_q [TREE_SIZE];
	logic [VALUE_WIDTH-1:0] rd_q;

	state_t                 state_q;
	logic [AW-1:0]          clr_q;
	logic [PW-1:0]          lo_q;
	logic [PW-1:0]          hi_q;
	logic [VALUE_WIDTH-1:0] acc_q;
	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] out_min_q;
	logic                   out_err_q;

	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [VALUE_WIDTH-1:0] wr_data;
	logic [AW-1:0]          rd_addr;
	logic [VALUE_WIDTH-1:0] mn;
	logic [PW-1:0]          parent;
	logic [PW-1:0]          hi_m1;
	logic [PW-1:0]          lo_p1;
	logic                   out_free;
	logic                   direct;
	logic                   res_load;

	assign mn       = (acc_q < rd_q) ? acc_q : rd_q;
	assign parent   = lo_q >> 1;
	assign hi_m1    = hi_q - 1'b1;
	assign lo_p1    = lo_q + 1'b1;
	assign out_free = !out_valid_q || out_ready;
	assign direct   = (q_ctrl.kind == rmpu_pkg::CMD_EMPTY) ||
		(q_ctrl.kind == rmpu_pkg::CMD_ERROR);

	assign q_pop     = (state_q == ST_IDLE) && !q_empty && (!direct || out_free);
	assign init_done = (state_q != ST_CLEAR);

	// A result enters the output register this cycle.
	assign res_load = (q_pop && direct) ||
		((state_q == ST_QTEST) && !(lo_q < hi_q) && out_free);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = lo_q[AW-1:0];
		wr_data = acc_q;
		rd_addr = lo_q[AW-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '1;
			end
			ST_ULEAF: begin
				wr_en   = 1'b1;
				rd_addr = lo_q[AW-1:0] ^ AW'(1);
			end
			ST_ULEVEL: begin
				wr_en   = 1'b1;
				wr_addr = parent[AW-1:0];
				wr_data = mn;
				rd_addr = parent[AW-1:0] ^ AW'(1);
			end
			ST_QTEST: begin
				if (!lo_q[0]) begin
					rd_addr = hi_m1[AW-1:0];
				end
			end
			ST_QLO: begin
				rd_addr = hi_m1[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tree_q[wr_addr] <= wr_data;
		end
		rd_q <= tree_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			out_min_q   <= '0;
			out_err_q   <= 1'b0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_pop) begin
						lo_q <= PW'(q_ctrl.first) + LEAF_BASE;
						hi_q <= PW'(q_ctrl.last) + LEAF_BASE + PW'(1);
						unique case (q_ctrl.kind) inside
							rmpu_pkg::CMD_UPDATE: begin
								acc_q   <= q_value ^ SIGN;
								state_q <= ST_ULEAF;
							end
							rmpu_pkg::CMD_QUERY: begin
								acc_q   <= '1;
								state_q <= ST_QTEST;
							end
							rmpu_pkg::CMD_EMPTY, rmpu_pkg::CMD_ERROR: begin
								out_min_q <= ~SIGN;
								out_err_q <= (q_ctrl.kind == rmpu_pkg::CMD_ERROR);
							end
							default: begin
							end
						endcase
					end
				end
				ST_ULEAF: begin
					state_q <= ST_ULEVEL;
				end
				ST_ULEVEL: begin
					acc_q <= mn;
					lo_q  <= parent;
					if (parent == ROOT) begin
						state_q <= ST_IDLE;
					end
				end
				ST_QTEST: begin
					if (!(lo_q < hi_q)) begin
						if (out_free) begin
							out_min_q <= acc_q ^ SIGN;
							out_err_q <= 1'b0;
							state_q   <= ST_IDLE;
						end
					end else if (lo_q[0]) begin
						state_q <= ST_QLO;
					end else if (hi_q[0]) begin
						state_q <= ST_QHI;
					end else begin
						lo_q <= lo_q >> 1;
						hi_q <= hi_q >> 1;
					end
				end
				ST_QLO: begin
					acc_q <= mn;
					if (hi_q[0]) begin
						lo_q    <= lo_p1;
						state_q <= ST_QHI;
					end else begin
						lo_q    <= lo_p1 >> 1;
						hi_q    <= hi_q >> 1;
						state_q <= ST_QTEST;
					end
				end
				ST_QHI: begin
					acc_q   <= mn;
					lo_q    <= lo_q >> 1;
					hi_q    <= hi_m1 >> 1;
					state_q <= ST_QTEST;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign out_minimum = out_min_q;
	assign out_error   = out_err_q;

	`RMPU_NEVER(a_pop_only_idle, clk, arst_n, q_pop && (state_q != ST_IDLE))
	`RMPU_NEVER(a_no_result_in_clear, clk, arst_n, (state_q == ST_CLEAR) && out_valid_q)

endmodule

@@ hdl/range_min_point_update.sv @@
// Channel   Direction  Handshake             Payload
// s_*       in         s_tvalid / s_tready   tuser: opcode; tdata: first, last, new_value
// m_*       out        m_tvalid / m_tready   tuser: range_error; tdata: minimum
// cfg_*     in         cfg_valid / cfg_ready cfg_data: active_length
//
// After reset the tree is swept to the largest value, one entry a cycle, over all
// 2 * MAX_LENGTH entries (2048 by default); s_tready stays low during the sweep.
// An update is the pop, one leaf write, then one parent write per level up to the
// root, each fed by a sibling read on the tree RAM. A query walks up the tree a
// level at a time, reading the node at each span end that needs one through the
// single read port of the tree RAM. Errors and empty spans are answered at the pop.
// A two-item queue lets the front accept while the back walks; a held result
// in the output register stalls the back end when it has a result to give, and
// the front only once the queue fills.
module range_min_point_update #(
	parameter int MAX_LENGTH  = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,

	// Input items
	input  logic s_tvalid,
	output logic s_tready,
	// [9:0] first_index, [19:10] last_index, [20 +: VALUE_WIDTH] new_value, zero fill
	input  logic [((2 * rmpu_pkg::IDX_W + VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
	// [0] opcode
	input  logic s_tuser,

	// Result items
	output logic m_tvalid,
	input  logic m_tready,
	// [VALUE_WIDTH-1:0] minimum, zero fill
	output logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
	// [0] range_error
	output logic m_tuser,

	// Configuration: active_length
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [rmpu_pkg::LEN_W-1:0] cfg_data
);

	localparam int IDX_W  = rmpu_pkg::IDX_W;
	localparam int CTRL_W = $bits(rmpu_pkg::cmd_ctrl_t);
	localparam int Q_W    = CTRL_W + VALUE_WIDTH;
	localparam int OUT_W  = ((VALUE_WIDTH + 7) / 8) * 8;

	logic [IDX_W-1:0]       in_first;
	logic [IDX_W-1:0]       in_last;
	logic [VALUE_WIDTH-1:0] in_value;

	logic                   init_done;
	logic                   q_full;
	logic                   q_empty;
	logic                   q_push;
	logic                   q_pop;
	rmpu_pkg::cmd_ctrl_t    push_ctrl;
	logic [VALUE_WIDTH-1:0] push_value;
	logic [Q_W-1:0]         pop_data;
	rmpu_pkg::cmd_ctrl_t    pop_ctrl;
	logic [VALUE_WIDTH-1:0] pop_value;
	logic [VALUE_WIDTH-1:0] res_min;

	// Unpack the input item.
	assign in_first = s_tdata[IDX_W-1:0];
	assign in_last  = s_tdata[2*IDX_W-1:IDX_W];
	assign in_value = s_tdata[2*IDX_W +: VALUE_WIDTH];

	// Front: hold the length register, classify the item, drop bad updates.
	rmpu_front #(
		.MAX_LENGTH  (MAX_LENGTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.opcode      (s_tuser),
		.first_index (in_first),
		.last_index  (in_last),
		.new_value   (in_value),
		.init_done   (init_done),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_ctrl      (push_ctrl),
		.q_value     (push_value)
	);

	// Decouple front and back.
	rmpu_queue #(
		.WIDTH (Q_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({push_value, push_ctrl}),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	assign pop_ctrl  = pop_data[CTRL_W-1:0];
	assign pop_value = pop_data[Q_W-1:CTRL_W];

	// Back: sweep the tree after reset, then walk it for each update and query.
	rmpu_back #(
		.MAX_LENGTH  (MAX_LENGTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.q_ctrl      (pop_ctrl),
		.q_value     (pop_value),
		.init_done   (init_done),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_minimum (res_min),
		.out_error   (m_tuser)
	);

	assign m_tdata = OUT_W'(res_min);

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

	localparam int IDX_W = rmpu_pkg::IDX_W;
	localparam int LEN_W = rmpu_pkg::LEN_W;
	localparam int VAL_W = 32;
	localparam int S_DATA_W = ((2 * IDX_W + VAL_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((VAL_W + 7) / 8) * 8;
	localparam int MAX_POS = 1024;
	localparam logic signed [VAL_W-1:0] VAL_LARGEST = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] VAL_LEAST = 32'sh8000_0000;
	// Three items can sit in the queue and the back end.
	localparam int SETTLE_CYCLES = 96;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int SQUEEZE_ITEMS = 80;
	localparam int CYCLE_LIMIT = 1_000_000;

	typedef struct {
		logic signed [VAL_W-1:0] minimum;
		logic range_error;
	} min_result_t;

	// Shadow copy of the array plus the queue of pending query answers.
	class min_tree_scoreboard;
		logic signed [VAL_W-1:0] cells [MAX_POS];
		logic [LEN_W-1:0] length_reg;
		min_result_t expected_q [$];
		int mismatches;

		function new();
			foreach (cells[k]) cells[k] = VAL_LARGEST;
			length_reg = rmpu_pkg::LEN_RESET;
			mismatches = 0;
		endfunction

		function void set_length(logic [LEN_W-1:0] len);
			length_reg = len;
		endfunction

		function int live_span();
			return (int'(length_reg) > MAX_POS) ? MAX_POS : int'(length_reg);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Apply an accepted item; a query queues its expected minimum.
		function void note_item(logic op, logic [IDX_W-1:0] first,
			logic [IDX_W-1:0] last, logic signed [VAL_W-1:0] value);
			int span;
			int f;
			int l;
			min_result_t res;
			span = live_span();
			f = int'(first);
			l = int'(last);
			if (op == rmpu_pkg::OP_UPDATE) begin
				if (f < span) cells[f] = value;
				return;
			end
			res.minimum = VAL_LARGEST;
			res.range_error = 1'b0;
			if (f >= span || l >= span) begin
				res.range_error = 1'b1;
			end else begin
				// empty span (first > last) leaves the largest value
				for (int k = f; k <= l; k++)
					if (cells[k] < res.minimum) res.minimum = cells[k];
			end
			expected_q.insert(expected_q.size(), res);
		endfunction

		function void check_result(logic [VAL_W-1:0] minimum, logic range_error);
			min_result_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] unexpected result: minimum %0d range_error %0b",
						$time, $signed(minimum), range_error);
				return;
			end
			want = expected_q.pop_front();
			if (minimum !== want.minimum || range_error !== want.range_error) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] mismatch: expected %0d/%0b, got %0d/%0b",
						$time, want.minimum, want.range_error,
						$signed(minimum), range_error);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	logic s_tvalid;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata;	// [9:0] first_index, [19:10] last_index, [51:20] new_value
	logic s_tuser;			// [0] opcode

	logic m_tvalid;
	logic m_tready;
	logic [M_DATA_W-1:0] m_tdata;	// [31:0] minimum
	logic m_tuser;			// [0] range_error

	logic cfg_valid;
	logic cfg_ready;
	logic [LEN_W-1:0] cfg_data;

	min_tree_scoreboard sb;
	bit src_bursty;
	bit sink_bursty;
	bit sink_hold_req;
	int cycle_count;

	range_min_point_update uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Check every result item taken at this edge against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata[VAL_W-1:0], m_tuser);
	end

	// Result side: random stalls, stretches of steady ready, and one long hold-off on request.
	initial begin : result_sink
		int n;
		m_tready <= 1'b0;
		@(posedge clk);
		forever begin
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				m_tready <= 1'b0;
				for (n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge clk);
			end else if (sink_bursty && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	// Offer one item, hold it until taken, note it, then maybe drop valid for a burst.
	task automatic send_item(input logic op, input int first, input int last,
		input int value);
		logic [IDX_W-1:0] f_bits;
		logic [IDX_W-1:0] l_bits;
		logic signed [VAL_W-1:0] v_bits;
		f_bits = IDX_W'(first);
		l_bits = IDX_W'(last);
		v_bits = value;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {{(S_DATA_W - 2 * IDX_W - VAL_W){1'b0}}, v_bits, l_bits, f_bits};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_item(op, f_bits, l_bits, v_bits);
		if (src_bursty && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	// Stop offering and wait until every expected result has arrived.
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Drain, let unchecked updates finish their walk, then write the active length.
	task automatic write_length(input int len);
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= LEN_W'(len);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		sb.set_length(LEN_W'(len));
	endtask

	// Random updates and queries at the current length; only items that do work count.
	task automatic run_phase(input int useful_items, input bit squeeze, input bit pause_mid);
		int done;
		int sent;
		int span;
		int sel;
		int reach;
		bit saved_bursty;
		logic op;
		int first;
		int last;
		logic signed [VAL_W-1:0] value;
		done = 0;
		sent = 0;
		span = sb.live_span();
		saved_bursty = src_bursty;
		if (squeeze) begin
			// back-to-back items against a stalled receiver: fill the block
			src_bursty = 1'b0;
			sink_hold_req = 1'b1;
		end
		while (done < useful_items) begin
			if (squeeze && sent == SQUEEZE_ITEMS) src_bursty = saved_bursty;
			if (pause_mid && done == useful_items / 2 && sent != 0) begin
				wait_for_results();
				pause_mid = 1'b0;
			end
			op = ($urandom_range(0, 99) < 45) ? rmpu_pkg::OP_UPDATE : rmpu_pkg::OP_QUERY;
			sel = $urandom_range(0, 19);
			if (span == 0 || sel == 0) begin
				first = $urandom_range(0, MAX_POS - 1);
				last = $urandom_range(0, MAX_POS - 1);
			end else begin
				first = $urandom_range(0, span - 1);
				if (sel == 1) begin
					last = $urandom_range(0, MAX_POS - 1);
				end else if (sel < 8) begin
					reach = $urandom_range(0, 15);
					last = (first + reach < span) ? first + reach : span - 1;
				end else begin
					last = $urandom_range(0, span - 1);
				end
				if (sel == 2) first = $urandom_range(0, MAX_POS - 1);
			end
			case ($urandom_range(0, 7))
				0: value = VAL_LARGEST;
				1: value = VAL_LEAST;
				2, 3: value = int'($urandom_range(0, 400)) - 200;
				default: value = $urandom;
			endcase
			if (op == rmpu_pkg::OP_QUERY || first < span) done++;
			sent++;
			send_item(op, first, last, value);
		end
		src_bursty = saved_bursty;
	endtask

	initial begin : stimulus
		sb = new();
		cycle_count = 0;
		src_bursty = 1'b1;
		sink_bursty = 1'b1;
		sink_hold_req = 1'b0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser <= rmpu_pkg::OP_UPDATE;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Cleared store at reset length: every query sees the largest value.
		send_item(rmpu_pkg::OP_QUERY, 0, MAX_POS - 1, 0);
		// Value and position extremes, alternating bit patterns.
		send_item(rmpu_pkg::OP_UPDATE, 0, 0, VAL_LEAST);
		send_item(rmpu_pkg::OP_UPDATE, MAX_POS - 1, 0, VAL_LARGEST);
		send_item(rmpu_pkg::OP_UPDATE, 512, MAX_POS - 1, -1);
		send_item(rmpu_pkg::OP_UPDATE, 511, 0, 0);
		send_item(rmpu_pkg::OP_UPDATE, 'h2AA, 'h155, 32'sh5555_5555);
		send_item(rmpu_pkg::OP_UPDATE, 'h155, 'h2AA, 32'shAAAA_AAAA);
		send_item(rmpu_pkg::OP_QUERY, 0, MAX_POS - 1, 0);
		send_item(rmpu_pkg::OP_QUERY, 1, MAX_POS - 1, 0);
		send_item(rmpu_pkg::OP_QUERY, MAX_POS - 1, MAX_POS - 1, 0);
		send_item(rmpu_pkg::OP_QUERY, 511, 511, 0);
		send_item(rmpu_pkg::OP_QUERY, 'h155, 'h2AA, 32'sh5555_5555);
		// Empty spans: first above last.
		send_item(rmpu_pkg::OP_QUERY, 'h2AA, 'h155, 0);
		send_item(rmpu_pkg::OP_QUERY, 700, 300, 0);

		// Length one: only position 0 is live; errors in either index order.
		write_length(1);
		send_item(rmpu_pkg::OP_QUERY, 0, 0, 0);
		send_item(rmpu_pkg::OP_QUERY, 0, 1, 0);
		send_item(rmpu_pkg::OP_QUERY, 1, 0, 0);
		send_item(rmpu_pkg::OP_UPDATE, 5, 0, 7);
		send_item(rmpu_pkg::OP_QUERY, MAX_POS - 1, MAX_POS - 1, 0);
		send_item(rmpu_pkg::OP_UPDATE, 0, 0, -5);
		send_item(rmpu_pkg::OP_QUERY, 0, 0, 0);

		run_phase(150, 1'b0, 1'b0);
		write_length(2);
		run_phase(120, 1'b0, 1'b0);
		// Length zero: everything out of range, updates dropped.
		write_length(0);
		run_phase(60, 1'b0, 1'b0);
		// Length above the array size clamps to the full array; old values survive.
		write_length(2047);
		run_phase(200, 1'b1, 1'b0);
		write_length(513);
		run_phase(200, 1'b0, 1'b1);
		write_length($urandom_range(1, MAX_POS));
		run_phase(200, 1'b0, 1'b0);
		write_length(3);
		run_phase(100, 1'b0, 1'b0);
		write_length($urandom_range(1, 64));
		run_phase(150, 1'b0, 1'b0);
		write_length(MAX_POS);
		run_phase(300, 1'b0, 1'b0);

		// Closing stretch at full rate on both sides.
		src_bursty = 1'b0;
		sink_bursty = 1'b0;
		run_phase(350, 1'b0, 1'b0);

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
